>>> hdl/multi_channel_led_blinker_assert.svh
// ----------------------------------------------------------------------------
// multi_channel_led_blinker_assert.svh
// Assertion macros for the LED blinker; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_LED_BLINKER_ASSERT_SVH
`define MULTI_CHANNEL_LED_BLINKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define MCLB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("mclb assertion failed");

// condition must never be seen outside reset
`define MCLB_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("mclb forbidden condition seen");

`else

`define MCLB_ASSERT(label, prop)
`define MCLB_NEVER(label, cond)

`endif

`endif

>>> hdl/mclb_pkg.sv
// ----------------------------------------------------------------------------
// mclb_pkg
// Shared constants and types of the multi-channel LED blinker.
// ----------------------------------------------------------------------------
package mclb_pkg;

  // number of LED channels (1 to 32)
  localparam int CHANNELS = 8;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // item field widths
  localparam int OPC_W    = 3;
  localparam int CHAN_W   = 8;
  localparam int PER_W    = 32;
  localparam int TIME_W   = 32;
  localparam int HP_W     = 31;
  localparam int LEVELS_W = 8;

  // command codes
  typedef enum logic [OPC_W-1:0] {
    OP_OFF    = 3'd0,
    OP_ON     = 3'd1,
    OP_TOGGLE = 3'd2,
    OP_BLINK  = 3'd3,
    OP_TICK   = 3'd4
  } opcode_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_CHK,
    ST_UPD,
    ST_OUT
  } state_t;

endpackage

>>> hdl/mclb_cmd_if.sv
// ----------------------------------------------------------------------------
// mclb_cmd_if
// Input channel of the LED blinker: one command or tick per item.
// ----------------------------------------------------------------------------
interface mclb_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [mclb_pkg::OPC_W-1:0]   opcode;
  logic [mclb_pkg::CHAN_W-1:0]  channel;
  logic [mclb_pkg::PER_W-1:0]   blink_period;

  modport source (output valid, output opcode, output channel, output blink_period,
                  input ready);
  modport sink (input valid, input opcode, input channel, input blink_period,
                output ready);
endinterface

>>> hdl/mclb_rsp_if.sv
// ----------------------------------------------------------------------------
// mclb_rsp_if
// Output channel of the LED blinker: one status item per input item.
// ----------------------------------------------------------------------------
interface mclb_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic [mclb_pkg::LEVELS_W-1:0]  led_levels;
  logic                           any_blinking;
  logic [mclb_pkg::HP_W-1:0]      wait_ms;

  modport source (output valid, output accepted, output led_levels,
                  output any_blinking, output wait_ms, input ready);
  modport sink (input valid, input accepted, input led_levels,
                input any_blinking, input wait_ms, output ready);
endinterface

>>> hdl/multi_channel_led_blinker.sv
// ----------------------------------------------------------------------------
// multi_channel_led_blinker
// LED blink controller: per-channel level and blink schedule, ms time base.
// ----------------------------------------------------------------------------
// Usage: items on cmd carry an opcode (off, on, toggle, blink, ms tick), a
// channel and a blink half period. Every accepted item gives exactly one item
// on rsp: accepted flag, levels of channels 0..7, any-blinking flag and the
// least ms left until the next toggle.
// Sequence: the command state applies the command, then the scan visits
// each channel in a due-check state (toggle and reschedule) and then a
// remaining-time minimum state, then the output state loads the output
// register. The scan is one shared subtract/compare path stepped by a
// channel counter, so one item is in flight and cmd.ready is low meanwhile.
// Intake: a new item is taken only in the idle state, once the result of
// the last item has been loaded into the output register.
// Stall: the result sits in an output register; if rsp.ready is low, the
// block still takes the next item and works on it, then holds in the
// output state until the register frees.
// Reset: time base zero, all LEDs off, no channel blinking, no result held.
// ----------------------------------------------------------------------------
`include "multi_channel_led_blinker_assert.svh"

module multi_channel_led_blinker (
  input logic      clk,
  input logic      rst,
  mclb_cmd_if.sink   cmd,
  mclb_rsp_if.source rsp
);
  import mclb_pkg::*;

  // sequencer
  state_t state;
  state_t state_next;
  logic   take_cmd;
  logic   load_rsp;
  logic   rsp_free;
  logic   scan_last;

  // latched item
  logic [OPC_W-1:0]  op_q;
  logic [CHAN_W-1:0] chan_q;
  logic [PER_W-1:0]  period_q;

  // block state
  logic [TIME_W-1:0] now_ms;
  logic [CHANNELS-1:0] led_level;
  logic [CHANNELS-1:0] blinking;
  logic [HP_W-1:0]   half_period [CHANNELS];
  logic [TIME_W-1:0] due_time [CHANNELS];

  // scan state
  logic [CH_W-1:0]   idx;
  logic              any_q;
  logic [HP_W-1:0]   wait_q;
  logic              acc_q;

  // shared scan datapath
  logic [TIME_W-1:0] due_rd;
  logic [HP_W-1:0]   hp_rd;
  logic [TIME_W-1:0] late;
  logic [TIME_W-1:0] remain;
  logic [HP_W-1:0]   remain_clip;
  logic              in_range;
  logic [CH_W-1:0]   chan_idx;
  logic [HP_W-1:0]   hp_clamped;
  logic [LEVELS_W-1:0] level_bits;

  assign rsp_free  = !rsp.valid || rsp.ready;
  assign scan_last = (idx == CH_W'(CHANNELS - 1));
  assign in_range  = (chan_q < CHAN_W'(CHANNELS));
  assign chan_idx  = chan_q[CH_W-1:0];
  assign hp_clamped = period_q[PER_W-1] ? {HP_W{1'b1}} : period_q[HP_W-1:0];

  // one channel read port, addressed by the scan counter
  assign due_rd      = due_time[idx];
  assign hp_rd       = half_period[idx];
  assign late        = now_ms - due_rd;
  assign remain      = due_rd - now_ms;
  assign remain_clip = remain[TIME_W-1] ? '0 : remain[HP_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (cmd.valid) state_next = ST_CMD;
      ST_CMD:  state_next = ST_CHK;
      ST_CHK:  state_next = ST_UPD;
      ST_UPD:  state_next = scan_last ? ST_OUT : ST_CHK;
      ST_OUT:  if (rsp_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    take_cmd = 1'b0;
    load_rsp = 1'b0;
    case (state)
      ST_IDLE: take_cmd = cmd.valid;
      ST_OUT:  load_rsp = rsp_free;
      default: begin
        take_cmd = 1'b0;
        load_rsp = 1'b0;
      end
    endcase
  end

  assign cmd.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // item capture
  always_ff @(posedge clk) begin
    if (take_cmd) begin
      op_q     <= cmd.opcode;
      chan_q   <= cmd.channel;
      period_q <= cmd.blink_period;
    end
  end

  // command apply, scan and time base
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms    <= '0;
      led_level <= '0;
      blinking  <= '0;
      idx       <= '0;
      any_q     <= 1'b0;
      wait_q    <= '0;
      acc_q     <= 1'b0;
    end else begin
      case (state)
        ST_CMD: begin
          idx    <= '0;
          any_q  <= 1'b0;
          wait_q <= '0;
          if (op_q == OP_TICK) begin
            now_ms <= now_ms + TIME_W'(1);
            acc_q  <= 1'b1;
          end else if (!in_range) begin
            acc_q <= 1'b0;
          end else begin
            acc_q <= 1'b1;
            case (op_q)
              OP_OFF: begin
                blinking[chan_idx]  <= 1'b0;
                led_level[chan_idx] <= 1'b0;
              end
              OP_ON: begin
                blinking[chan_idx]  <= 1'b0;
                led_level[chan_idx] <= 1'b1;
              end
              OP_TOGGLE: begin
                blinking[chan_idx]  <= 1'b0;
                led_level[chan_idx] <= !led_level[chan_idx];
              end
              OP_BLINK: begin
                if (period_q == '0) begin
                  blinking[chan_idx]  <= 1'b0;
                  led_level[chan_idx] <= 1'b0;
                end else begin
                  blinking[chan_idx] <= 1'b1;
                end
              end
              default: acc_q <= 1'b0;
            endcase
          end
        end
        // due check: toggle and reschedule
        ST_CHK: begin
          if (blinking[idx] && !late[TIME_W-1]) begin
            led_level[idx] <= !led_level[idx];
          end
        end
        // remaining-time minimum
        ST_UPD: begin
          if (blinking[idx]) begin
            any_q <= 1'b1;
            if (!any_q || remain_clip < wait_q) wait_q <= remain_clip;
          end
          if (!scan_last) idx <= idx + CH_W'(1);
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  // schedule storage, written by blink commands and the due check
  always_ff @(posedge clk) begin
    if (state == ST_CMD && op_q == OP_BLINK && in_range && period_q != '0) begin
      half_period[chan_idx] <= hp_clamped;
      due_time[chan_idx]    <= now_ms;
    end else if (state == ST_CHK && blinking[idx] && !late[TIME_W-1]) begin
      due_time[idx] <= now_ms + {1'b0, hp_rd};
    end
  end

  // levels of channels 0..7
  for (genvar g = 0; g < LEVELS_W; g++) begin : g_lvl
    if (g < CHANNELS) begin : g_on
      assign level_bits[g] = led_level[g];
    end else begin : g_off
      assign level_bits[g] = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.accepted     <= acc_q;
      rsp.led_levels   <= level_bits;
      rsp.any_blinking <= any_q;
      rsp.wait_ms      <= wait_q;
    end
  end

  // assertions
  `MCLB_ASSERT(a_wait_zero_idle, rsp.valid && !rsp.any_blinking |-> rsp.wait_ms == '0)
  `MCLB_ASSERT(a_busy_after_take, cmd.valid && cmd.ready |=> !cmd.ready)
  `MCLB_ASSERT(a_tick_advances,
               state == ST_CMD && op_q == OP_TICK |=> now_ms == $past(now_ms) + TIME_W'(1))
  `MCLB_NEVER(a_idx_range, idx > CH_W'(CHANNELS - 1))

endmodule
